[rtl/core/mdc_pkg.sv]
// Shared types, constants and helper functions for the determinant unit.
// Used by mdc_ctrl, mdc_datapath and matrix_determinant_cofactor_unit.
package mdc_pkg;

  localparam int unsigned MaxSizeDefault     = 4;
  localparam int unsigned ElementBitsDefault = 16;

  localparam int unsigned StoreDepth    = 16;
  localparam int unsigned StoreAddrBits = 4;
  localparam int unsigned ElemWidth     = 16;
  localparam int unsigned SizeWidth     = 3;
  localparam int unsigned CountWidth    = 5;
  localparam int unsigned MinorWidth    = 52;
  localparam int unsigned SplitBit      = 26;
  localparam int unsigned ProdWidth     = 43;
  localparam int unsigned AccWidth      = 68;
  localparam int unsigned DetWidth      = 64;
  localparam int unsigned StatusWidth   = 2;

  localparam logic [StatusWidth-1:0] StatusOk        = 2'd0;
  localparam logic [StatusWidth-1:0] StatusNotSquare = 2'd1;
  localparam logic [StatusWidth-1:0] StatusSaturated = 2'd2;

  localparam logic CfgRowCount    = 1'b0;
  localparam logic CfgColumnCount = 1'b1;

  // Expansion phases: 2x2 minors of the bottom rows, 3x3 minors, top row.
  typedef enum logic [1:0] {
    PhPair   = 2'd0,
    PhTriple = 2'd1,
    PhTop    = 2'd2
  } phase_e;

  typedef struct packed {
    logic                     store_we;
    logic [StoreAddrBits-1:0] store_addr;
    logic                     emit_nonsquare;
    logic                     op_valid;
    phase_e                   phase;
    logic [2:0]               grp;
    logic [1:0]               term;
    logic                     half;
    logic [SizeWidth-1:0]     size;
  } mdc_cmd_t;

  typedef struct packed {
    logic out_busy;
  } mdc_status_t;

  function automatic logic [1:0] last_term(phase_e p);
    logic [1:0] r;
    unique case (p)
      PhPair:   r = 2'd1;
      PhTriple: r = 2'd2;
      PhTop:    r = 2'd3;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] last_grp(phase_e p);
    logic [2:0] r;
    unique case (p)
      PhPair:   r = 3'd5;
      PhTriple: r = 3'd3;
      PhTop:    r = 3'd0;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/mdc_ctrl.sv]
// Controller for the determinant unit: configuration registers, load counter
// and the sequencer that steps the datapath through the expansion. Uses mdc_pkg.
module mdc_ctrl #(
  parameter int unsigned MAX_SIZE = mdc_pkg::MaxSizeDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_index_i,
  input  logic [mdc_pkg::SizeWidth-1:0]  cfg_data_i,
  input  mdc_pkg::mdc_status_t           status_i,
  output mdc_pkg::mdc_cmd_t              cmd_o
);
  import mdc_pkg::*;

  typedef enum logic [2:0] {
    SLoad  = 3'b001,
    SIssue = 3'b010,
    SDrain = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [SizeWidth-1:0]  row_q, row_d, col_q, col_d;
  logic [CountWidth-1:0] load_cnt_q, load_cnt_d;
  phase_e                phase_q, phase_d;
  logic [2:0]            grp_q, grp_d;
  logic [1:0]            term_q, term_d;
  logic                  half_q, half_d;
  logic                  drain_q, drain_d;

  logic [SizeWidth-1:0]  rows, cols;
  logic [CountWidth-1:0] total;
  logic                  completing, accept;

  function automatic logic [SizeWidth-1:0] clamp_size(logic [SizeWidth-1:0] v);
    logic [SizeWidth-1:0] r;
    if (v == '0) r = SizeWidth'(1);
    else if (v > SizeWidth'(MAX_SIZE)) r = SizeWidth'(MAX_SIZE);
    else r = v;
    return r;
  endfunction

  assign rows       = clamp_size(row_q);
  assign cols       = clamp_size(col_q);
  assign total      = CountWidth'({2'b00, rows} * {2'b00, cols});
  assign completing = (load_cnt_q + CountWidth'(1)) >= total;
  // A finished matrix needs a free output slot before it may start.
  assign in_ready_o = (state_q == SLoad) && !(completing && status_i.out_busy);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    load_cnt_d = load_cnt_q;
    phase_d    = phase_q;
    grp_d      = grp_q;
    term_d     = term_q;
    half_d     = half_q;
    drain_d    = drain_q;

    cmd_o                = '0;
    cmd_o.store_addr     = load_cnt_q[StoreAddrBits-1:0];
    cmd_o.phase          = phase_q;
    cmd_o.grp            = grp_q;
    cmd_o.term           = term_q;
    cmd_o.half           = half_q;
    cmd_o.size           = rows;

    unique case (state_q)
      SLoad: begin
        if (accept) begin
          cmd_o.store_we = 1'b1;
          if (completing) begin
            load_cnt_d = '0;
            if (rows != cols) begin
              cmd_o.emit_nonsquare = 1'b1;
            end else begin
              state_d = SIssue;
              phase_d = PhPair;
              grp_d   = '0;
              term_d  = '0;
              half_d  = 1'b0;
            end
          end else begin
            load_cnt_d = load_cnt_q + CountWidth'(1);
          end
        end
      end
      SIssue: begin
        cmd_o.op_valid = 1'b1;
        if (!half_q) begin
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if (term_q == last_term(phase_q)) begin
            term_d = '0;
            if (grp_q == last_grp(phase_q)) begin
              grp_d   = '0;
              drain_d = 1'b1;
              state_d = SDrain;
            end else begin
              grp_d = grp_q + 3'd1;
            end
          end else begin
            term_d = term_q + 2'd1;
          end
        end
      end
      SDrain: begin
        // The idle drain state lets the last product reach its minor register.
        if (drain_q) begin
          drain_d = 1'b0;
        end else begin
          unique case (phase_q)
            PhPair: begin
              phase_d = PhTriple;
              state_d = SIssue;
            end
            PhTriple: begin
              phase_d = PhTop;
              state_d = SIssue;
            end
            default: begin
              phase_d = PhPair;
              state_d = SLoad;
            end
          endcase
        end
      end
      default: state_d = SLoad;
    endcase

    if (cfg_valid_i) begin
      load_cnt_d = '0;
      if (cfg_index_i == CfgRowCount) row_d = cfg_data_i;
      else col_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SLoad;
      row_q      <= SizeWidth'(3);
      col_q      <= SizeWidth'(3);
      load_cnt_q <= '0;
      phase_q    <= PhPair;
      grp_q      <= '0;
      term_q     <= '0;
      half_q     <= 1'b0;
      drain_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      load_cnt_q <= load_cnt_d;
      phase_q    <= phase_d;
      grp_q      <= grp_d;
      term_q     <= term_d;
      half_q     <= half_d;
      drain_q    <= drain_d;
    end
  end

endmodule

[rtl/core/mdc_datapath.sv]
// Datapath of the determinant unit: element store, shared 16x27 multiplier,
// accumulator, minor registers and the output register. Uses mdc_pkg.
module mdc_datapath #(
  parameter int unsigned ELEMENT_BITS = mdc_pkg::ElementBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mdc_pkg::mdc_cmd_t                cmd_i,
  input  logic [mdc_pkg::ElemWidth-1:0]    in_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [mdc_pkg::DetWidth-1:0]     det_o,
  output logic [mdc_pkg::StatusWidth-1:0]  out_status_o,
  output mdc_pkg::mdc_status_t             dp_status_o
);
  import mdc_pkg::*;

  typedef struct packed {
    logic       valid;
    phase_e     phase;
    logic [2:0] grp;
    logic       half;
    logic       sub;
    logic       first;
    logic       last;
  } stage_ctl_t;

  logic signed [ELEMENT_BITS-1:0] elem_low;
  logic signed [ElemWidth-1:0]    elem_ext;

  logic [ElemWidth-1:0]  store_q [StoreDepth];
  logic [ElemWidth-1:0]  rd_a_q, rd_b_q;
  logic                  a_pad_q, a_one_q, b_pad_q, b_one_q;
  logic [MinorWidth-1:0] minor_q, minor_sel;
  stage_ctl_t            ctl1_q, ctl2_q, ctl0;

  logic [1:0] a_row, a_col, b_col, c0, c1, ox, oy, k;

  logic [MinorWidth-1:0] m2_q [6];
  logic [MinorWidth-1:0] m3_q [4];

  logic signed [ElemWidth-1:0]  a_val, b_elem;
  logic signed [MinorWidth-1:0] b_full;
  logic signed [SplitBit:0]     b_part;
  logic signed [ProdWidth-1:0]  prod_d, prod_q;
  logic signed [AccWidth-1:0]   term_v, base_v, acc_d, acc_q;

  logic                   out_valid_q, out_valid_d;
  logic [DetWidth-1:0]    det_q;
  logic [StatusWidth-1:0] stat_q;
  logic                   final_wr, sat_fits;

  function automatic logic [1:0] pair_lo(logic [2:0] g);
    logic [1:0] r;
    unique case (g)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_hi(logic [2:0] g);
    logic [1:0] r;
    unique case (g)
      3'd0:         r = 2'd1;
      3'd1, 3'd3:   r = 2'd2;
      default:      r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pair_idx(logic [1:0] x, logic [1:0] y);
    logic [2:0] r;
    unique case ({x, y})
      4'b0001: r = 3'd0;
      4'b0010: r = 3'd1;
      4'b0011: r = 3'd2;
      4'b0110: r = 3'd3;
      4'b0111: r = 3'd4;
      4'b1011: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Column of the t-th entry of a row once column kk is struck out.
  function automatic logic [1:0] col_of(logic [1:0] t, logic [1:0] kk);
    return (t < kk) ? t : 2'(t + 2'd1);
  endfunction

  // A size-n matrix sits in the lower right of a 4x4 frame whose other
  // entries form an identity, so one fixed schedule serves every size.
  function automatic logic [1:0] frame_off(logic [SizeWidth-1:0] n);
    return 2'(3'd4 - n);
  endfunction

  function automatic logic is_pad(logic [1:0] r, logic [1:0] c, logic [SizeWidth-1:0] n);
    return (r < frame_off(n)) || (c < frame_off(n));
  endfunction

  function automatic logic [StoreAddrBits-1:0] elem_index(logic [1:0] r, logic [1:0] c,
                                                         logic [SizeWidth-1:0] n);
    logic [1:0] rr, cc;
    rr = 2'(r - frame_off(n));
    cc = 2'(c - frame_off(n));
    return StoreAddrBits'({2'b00, rr} * {1'b0, n}) + {2'b00, cc};
  endfunction

  assign elem_low = in_data_i[ELEMENT_BITS-1:0];
  assign elem_ext = ElemWidth'(elem_low);

  // Operand decode for the current command.
  always_comb begin
    a_row     = 2'd0;
    a_col     = 2'd0;
    b_col     = 2'd0;
    c0        = pair_lo(cmd_i.grp);
    c1        = pair_hi(cmd_i.grp);
    k         = cmd_i.grp[1:0];
    ox        = 2'd0;
    oy        = 2'd0;
    minor_sel = '0;
    unique case (cmd_i.phase)
      PhPair: begin
        a_row = 2'd2;
        a_col = cmd_i.term[0] ? c1 : c0;
        b_col = cmd_i.term[0] ? c0 : c1;
      end
      PhTriple: begin
        a_row = 2'd1;
        a_col = col_of(cmd_i.term, k);
        unique case (cmd_i.term)
          2'd0: begin
            ox = col_of(2'd1, k);
            oy = col_of(2'd2, k);
          end
          2'd1: begin
            ox = col_of(2'd0, k);
            oy = col_of(2'd2, k);
          end
          default: begin
            ox = col_of(2'd0, k);
            oy = col_of(2'd1, k);
          end
        endcase
        minor_sel = m2_q[pair_idx(ox, oy)];
      end
      PhTop: begin
        a_row     = 2'd0;
        a_col     = cmd_i.term;
        minor_sel = m3_q[cmd_i.term];
      end
      default: ;
    endcase
    ctl0.valid = cmd_i.op_valid;
    ctl0.phase = cmd_i.phase;
    ctl0.grp   = cmd_i.grp;
    ctl0.half  = cmd_i.half;
    ctl0.sub   = cmd_i.term[0];
    ctl0.first = (cmd_i.term == 2'd0) && !cmd_i.half;
    ctl0.last  = (cmd_i.term == last_term(cmd_i.phase)) && cmd_i.half;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) store_q[cmd_i.store_addr] <= elem_ext;
    rd_a_q  <= store_q[elem_index(a_row, a_col, cmd_i.size)];
    rd_b_q  <= store_q[elem_index(2'd3, b_col, cmd_i.size)];
    a_pad_q <= is_pad(a_row, a_col, cmd_i.size);
    a_one_q <= (a_row == a_col);
    b_pad_q <= is_pad(2'd3, b_col, cmd_i.size);
    b_one_q <= (b_col == 2'd3);
    minor_q <= minor_sel;
  end

  // Multiply stage: the B operand is split into a signed upper half and an
  // unsigned lower half, each taking one pass through the multiplier.
  always_comb begin
    a_val  = a_pad_q ? (a_one_q ? ElemWidth'(1) : '0) : rd_a_q;
    b_elem = b_pad_q ? (b_one_q ? ElemWidth'(1) : '0) : rd_b_q;
    b_full = (ctl1_q.phase == PhPair) ? MinorWidth'(b_elem) : minor_q;
    b_part = ctl1_q.half ? {1'b0, b_full[SplitBit-1:0]}
                         : (SplitBit+1)'(signed'(b_full[MinorWidth-1:SplitBit]));
    prod_d = ProdWidth'(a_val) * ProdWidth'(b_part);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    term_v   = ctl2_q.half ? AccWidth'(prod_q) : (AccWidth'(prod_q) <<< SplitBit);
    base_v   = ctl2_q.first ? '0 : acc_q;
    acc_d    = ctl2_q.sub ? (base_v - term_v) : (base_v + term_v);
    sat_fits = (&acc_d[AccWidth-1:DetWidth-1]) || !(|acc_d[AccWidth-1:DetWidth-1]);
    final_wr = ctl2_q.valid && ctl2_q.last && (ctl2_q.phase == PhTop);
  end

  always_ff @(posedge clk_i) begin
    if (ctl2_q.valid) acc_q <= acc_d;
    if (ctl2_q.valid && ctl2_q.last && (ctl2_q.phase == PhPair))
      m2_q[ctl2_q.grp] <= acc_d[MinorWidth-1:0];
    if (ctl2_q.valid && ctl2_q.last && (ctl2_q.phase == PhTriple))
      m3_q[ctl2_q.grp[1:0]] <= acc_d[MinorWidth-1:0];
    if (cmd_i.emit_nonsquare) begin
      det_q  <= '0;
      stat_q <= StatusNotSquare;
    end else if (final_wr) begin
      if (sat_fits) begin
        det_q  <= acc_d[DetWidth-1:0];
        stat_q <= StatusOk;
      end else begin
        det_q  <= acc_d[AccWidth-1] ? {1'b1, {(DetWidth-1){1'b0}}}
                                    : {1'b0, {(DetWidth-1){1'b1}}};
        stat_q <= StatusSaturated;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_nonsquare || final_wr) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q      <= '0;
      ctl2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctl1_q      <= ctl0;
      ctl2_q      <= ctl1_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign det_o                = det_q;
  assign out_status_o         = stat_q;
  assign dp_status_o.out_busy = out_valid_q && !out_ready_i;

  a_nonsquare_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_nonsquare |-> !(out_valid_q && !out_ready_i))
    else $error("non-square result written over a pending result");

  a_final_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_wr |-> !out_valid_q)
    else $error("determinant finished while the output register was occupied");

  a_no_load_during_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op_valid || ctl1_q.valid || ctl2_q.valid) |-> !cmd_i.store_we)
    else $error("element store written while the expansion is running");

endmodule

[rtl/core/matrix_determinant_cofactor_unit.sv]
// Top level of the determinant unit: joins the controller and the datapath.
// Depends on mdc_pkg, mdc_ctrl and mdc_datapath.
//
// Usage: set row_count (index 0) and column_count (index 1) on the cfg
// channel; any write restarts the element load. Stream the matrix elements
// row-major on s_axis, one per transaction. After the last element of a
// matrix the unit returns one transaction on m_axis: the determinant in
// tdata and the status in tuser (0 ok, 1 not square, 2 saturated).
// Elements load at one per cycle while s_axis_tready is high. A non-square
// matrix answers on the cycle after its last element. A square matrix runs a
// fixed cofactor schedule of 56 multiplier passes plus drain cycles, the same
// whatever the size, because smaller matrices are framed by an identity in a
// 4x4 schedule. The single shared multiplier paces this whole schedule.
// While the expansion runs, s_axis_tready is low. A result waiting on a
// stalled receiver does not stop the next load; only the last element of
// the next matrix waits until the output register is free.
// Reset clears the load count and sets both sizes to 3.
module matrix_determinant_cofactor_unit #(
  parameter int unsigned MAX_SIZE     = mdc_pkg::MaxSizeDefault,
  parameter int unsigned ELEMENT_BITS = mdc_pkg::ElementBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mdc_pkg::ElemWidth-1:0]   s_axis_tdata,  // [15:0] element_value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mdc_pkg::DetWidth-1:0]    m_axis_tdata,  // [63:0] determinant
  output logic [mdc_pkg::StatusWidth-1:0] m_axis_tuser,  // [1:0] status
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [mdc_pkg::SizeWidth-1:0]   cfg_data_i
);
  import mdc_pkg::*;

  mdc_cmd_t    cmd;
  mdc_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  mdc_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  mdc_datapath #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_data_i    (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .det_o        (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .dp_status_o  (dp_status)
  );

endmodule

[dv/matrix_determinant_cofactor_unit_tb.sv]
// Self-checking testbench for matrix_determinant_cofactor_unit.
// Drives elements and size writes, predicts each determinant and status, and
// checks every m_axis transaction. Depends on mdc_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module matrix_determinant_cofactor_unit_tb;
  import mdc_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainWait  = 80;

  typedef struct {
    logic [DetWidth-1:0]    det;
    logic [StatusWidth-1:0] status;
  } det_result_t;

  typedef enum logic {RowCfg, RowElem} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic                   idx;
    logic [SizeWidth-1:0]   size;
    logic [ElemWidth-1:0]   elem;
    bit                     typed;
    det_result_t            res;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [ElemWidth-1:0]   s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [DetWidth-1:0]    m_axis_tdata;
  logic [StatusWidth-1:0] m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_index_i;
  logic [SizeWidth-1:0]   cfg_data_i;

  matrix_determinant_cofactor_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Predictor state.
  longint               elem_store [StoreDepth];
  int unsigned          load_cnt;
  logic [SizeWidth-1:0] rows_reg;
  logic [SizeWidth-1:0] cols_reg;

  det_result_t  pending_dets[$];
  stim_row_t    directed_rows[$];
  int unsigned  err_cnt;
  int unsigned  cycle_cnt;
  int unsigned  elems_sent;
  int unsigned  ok_seen, nonsquare_seen, sat_seen;
  bit           calm;
  int unsigned  hold_cnt;
  int unsigned  rdy_burst;

  initial begin
    clk_i = 1'b0;
    forever begin
      #10 clk_i = 1'b1;
      #10 clk_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_dets.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(logic [SizeWidth-1:0] v);
    if (v == 0) return 1;
    if (v > MaxSizeDefault) return MaxSizeDefault;
    return v;
  endfunction

  function automatic longint minor_det(int unsigned r, int unsigned mask, int unsigned n,
                                       int unsigned dim);
    longint      sum;
    longint      t;
    int unsigned pos;
    sum = 0;
    pos = 0;
    for (int unsigned c = 0; c < dim; c++) begin
      if (((mask >> c) & 1) == 0) continue;
      if (n <= 1) return elem_store[r * dim + c];
      t = elem_store[r * dim + c] * minor_det(r + 1, mask & ~(1 << c), n - 1, dim);
      sum = pos[0] ? sum - t : sum + t;
      pos++;
    end
    return sum;
  endfunction

  // Takes one accepted element; returns 1 when it completes a matrix.
  function automatic bit predict_det(logic [ElemWidth-1:0] v, output det_result_t res);
    int unsigned        rows, cols, n;
    logic signed [127:0] acc;
    longint             t;
    rows = clamp_size(rows_reg);
    cols = clamp_size(cols_reg);
    if (load_cnt < StoreDepth) elem_store[load_cnt] = longint'($signed(v));
    load_cnt++;
    if (load_cnt < rows * cols) return 0;
    load_cnt = 0;
    if (rows != cols) begin
      res.det = '0;
      res.status = StatusNotSquare;
      return 1;
    end
    n = rows;
    acc = '0;
    if (n == 1) acc = elem_store[0];
    else begin
      for (int unsigned k = 0; k < n; k++) begin
        t = elem_store[k] * minor_det(1, ((1 << n) - 1) & ~(1 << k), n - 1, n);
        acc = k[0] ? acc - t : acc + t;
      end
    end
    // The exact sum fits 64 bits only when its top 65 bits agree.
    if (acc[127:63] == '0 || acc[127:63] == '1) begin
      res.det = acc[63:0];
      res.status = StatusOk;
    end else begin
      res.det = acc[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      res.status = StatusSaturated;
    end
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    det_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_dets.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 64'd0);
      end else begin
        want = pending_dets.pop_front();
        if (m_axis_tdata !== want.det) report_mismatch("determinant", m_axis_tdata, want.det);
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        case (want.status)
          StatusOk:        ok_seen++;
          StatusNotSquare: nonsquare_seen++;
          default:         sat_seen++;
        endcase
      end
    end
  end

  // Receiver: random stall bursts, one long hold, none in the calm tail.
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (rdy_burst > 0) begin
      m_axis_tready <= 1'b0;
      rdy_burst <= rdy_burst - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      rdy_burst <= $urandom_range(0, 18);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // The sender stops offering before it waits, so no element is taken twice.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_dets.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(logic idx, logic [SizeWidth-1:0] val);
    wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (DrainWait) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgRowCount) rows_reg = val;
    else cols_reg = val;
    load_cnt = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_element(logic [ElemWidth-1:0] v, bit typed, det_result_t typed_res);
    det_result_t res;
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    elems_sent++;
    if (predict_det(v, res)) pending_dets.push_back(typed ? typed_res : res);
  endtask

  task automatic add_cfg(logic idx, logic [SizeWidth-1:0] val);
    stim_row_t r;
    r.kind = RowCfg;
    r.idx = idx;
    r.size = val;
    directed_rows.push_back(r);
  endtask

  task automatic add_elem(logic [ElemWidth-1:0] v, bit typed = 0,
                          logic [DetWidth-1:0] det = '0, logic [1:0] st = StatusOk);
    stim_row_t r;
    r.kind = RowElem;
    r.elem = v;
    r.typed = typed;
    r.res.det = det;
    r.res.status = st;
    directed_rows.push_back(r);
  endtask

  // Element (r, c) of a 4x4 Hadamard pattern at full scale, rows optionally negated.
  function automatic logic [ElemWidth-1:0] hadamard_elem(int unsigned r, int unsigned c,
                                                         logic [3:0] flip);
    bit neg;
    neg = ^(r[1:0] & c[1:0]) ^ flip[r];
    return neg ? -16'sd32767 : 16'sd32767;
  endfunction

  function automatic logic [ElemWidth-1:0] pick_elem(int unsigned style, int unsigned pos,
                                                     logic [3:0] flip);
    case (style)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 16)) - 8);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return hadamard_elem(pos / 4, pos % 4, flip);
    endcase
  endfunction

  initial begin
    int unsigned          total, n_mat, style, cut;
    logic [SizeWidth-1:0] rv, cv;
    logic [3:0]           flip;
    bit                   held, paused;
    det_result_t          none;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgRowCount;
    cfg_data_i = '0;
    cycle_cnt = 0;
    err_cnt = 0;
    elems_sent = 0;
    ok_seen = 0;
    nonsquare_seen = 0;
    sat_seen = 0;
    calm = 0;
    hold_cnt = 0;
    rdy_burst = 0;
    load_cnt = 0;
    rows_reg = 3'd3;
    cols_reg = 3'd3;
    held = 0;
    paused = 0;
    none.det = '0;
    none.status = StatusOk;
    foreach (elem_store[i]) elem_store[i] = 0;

    // Directed part: reset size 3x3 with an identity, then the size extremes.
    for (int unsigned i = 0; i < 9; i++) add_elem((i % 4 == 0) ? 16'd1 : 16'd0, i == 8, 64'd1);
    add_cfg(CfgRowCount, 3'd1);
    add_cfg(CfgColumnCount, 3'd1);
    add_elem(16'h8000, 1, -64'sd32768);
    add_elem(16'h7fff, 1, 64'd32767);
    add_cfg(CfgRowCount, 3'd2);
    add_cfg(CfgColumnCount, 3'd3);
    for (int unsigned i = 0; i < 6; i++)
      add_elem(i[0] ? 16'h7fff : 16'h8000, i == 5, 64'd0, StatusNotSquare);
    add_cfg(CfgRowCount, 3'd0);
    add_cfg(CfgColumnCount, 3'd0);
    add_elem(16'hfffb, 1, -64'sd5);
    // Sizes above the maximum act as 4; a full-scale Hadamard pattern saturates high.
    add_cfg(CfgRowCount, 3'd7);
    add_cfg(CfgColumnCount, 3'd5);
    for (int unsigned i = 0; i < 16; i++)
      add_elem(hadamard_elem(i / 4, i % 4, 4'b0000), i == 15, {1'b0, {63{1'b1}}},
               StatusSaturated);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowCfg) write_size(directed_rows[i].idx, directed_rows[i].size);
      else send_element(directed_rows[i].elem, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random part: mostly complete matrices, some broken loads cut by a size write.
    while (elems_sent < 625) begin
      rv = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 3) != 0) cv = (rv >= 4) ? 3'($urandom_range(4, 7)) : rv;
      else cv = 3'($urandom_range(0, 7));
      write_size(CfgRowCount, rv);
      write_size(CfgColumnCount, cv);
      total = clamp_size(rv) * clamp_size(cv);
      n_mat = $urandom_range(1, 4);
      for (int unsigned m = 0; m < n_mat; m++) begin
        style = $urandom_range(0, 3);
        if (style == 3 && total != 16) style = 0;
        flip = 4'($urandom_range(0, 15));
        cut = ($urandom_range(0, 9) == 0 && total > 1) ? $urandom_range(1, total - 1) : total;
        for (int unsigned e = 0; e < cut; e++) send_element(pick_elem(style, e, flip), 0, none);
        if (!held && elems_sent > 220) begin
          held = 1;
          hold_cnt = 600;
        end
        if (!paused && elems_sent > 380) begin
          paused = 1;
          wait_drained();
        end
        calm = elems_sent > 540;
        if (cut < total) break;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    $display("Sent %0d elements; checked %0d square, %0d non-square, %0d saturated results.",
             elems_sent, ok_seen, nonsquare_seen, sat_seen);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL");
    end
    $finish;
  end

endmodule
